@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");
// Implication whose consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/tlfs_pkg.sv @@
// Shared codes, reset values and controller/datapath interface types for the
// three-level feedback scheduler. No dependencies.
package tlfs_pkg;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [1:0] LVL_LOW    = 2'd0;
    localparam logic [1:0] LVL_MEDIUM = 2'd1;
    localparam logic [1:0] LVL_HIGH   = 2'd2;

    localparam logic [1:0] PRIO_MEDIUM = 2'd1;
    localparam logic [1:0] PRIO_HIGH   = 2'd2;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_PICKED   = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] CFG_QUANTUM_HIGH   = 2'd0;
    localparam logic [1:0] CFG_QUANTUM_MEDIUM = 2'd1;
    localparam logic [1:0] CFG_QUANTUM_LOW    = 2'd2;

    localparam int QUANTUM_W = 16;
    localparam int TICK_W    = 16;

    localparam logic [QUANTUM_W-1:0] QUANTUM_HIGH_RST   = 16'd50;
    localparam logic [QUANTUM_W-1:0] QUANTUM_MEDIUM_RST = 16'd100;
    localparam logic [QUANTUM_W-1:0] QUANTUM_LOW_RST    = 16'd1000;

    // Controller to datapath
    typedef struct packed {
        logic       capture;    // latch the accepted transaction
        logic       push;       // append latched id to its level
        logic       set_tick;   // record the new tick count
        logic       copy_rd;    // boost: read and pop a medium/low head
        logic       copy_wr;    // boost: append last read id to high
        logic       pop_rd;     // read and pop the highest non-empty head
        logic       load_out;   // load the result register
        logic [1:0] out_status;
    } tlfs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic dequeue;
        logic full;
        logic empty;
        logic tick_changed;
        logic src_nonempty;     // medium or low still holds entries
    } tlfs_sts_t;

    function automatic logic [1:0] prio_to_level(input logic [1:0] prio);
        logic [1:0] lvl;
        if (prio == PRIO_HIGH) begin
            lvl = LVL_HIGH;
        end else if (prio == PRIO_MEDIUM) begin
            lvl = LVL_MEDIUM;
        end else begin
            lvl = LVL_LOW;
        end
        return lvl;
    endfunction

endpackage

@@ rtl/core/tlfs_dpath.sv @@
// Datapath of the scheduler: queue memory, head/count pointers, quantum
// registers and result register. Depends on tlfs_pkg.
module tlfs_dpath #(
    parameter int QUEUE_DEPTH    = 32,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_operation,
    input  logic [THREAD_ID_BITS-1:0]      s_thread_id,
    input  logic [1:0]                     s_thread_priority,
    input  logic [tlfs_pkg::TICK_W-1:0]    s_tick_count,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [tlfs_pkg::QUANTUM_W-1:0] cfg_wr_data,
    input  tlfs_pkg::tlfs_cmd_t            cmd,
    output tlfs_pkg::tlfs_sts_t            sts,
    output logic [1:0]                     m_status,
    output logic [THREAD_ID_BITS-1:0]      m_picked_thread,
    output logic [1:0]                     m_picked_level,
    output logic [tlfs_pkg::QUANTUM_W-1:0] m_quantum
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 2;
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

    logic                           op_reg;
    logic [THREAD_ID_BITS-1:0]      id_reg;
    logic [1:0]                     prio_reg;
    logic [tlfs_pkg::TICK_W-1:0]    tick_reg;
    logic [tlfs_pkg::TICK_W-1:0]    last_tick_reg;
    logic [tlfs_pkg::QUANTUM_W-1:0] q_high_reg;
    logic [tlfs_pkg::QUANTUM_W-1:0] q_medium_reg;
    logic [tlfs_pkg::QUANTUM_W-1:0] q_low_reg;

    logic [PTR_W-1:0] head_reg   [0:2];
    logic [PTR_W-1:0] head_next  [0:2];
    logic [CNT_W-1:0] count_reg  [0:2];
    logic [CNT_W-1:0] count_next [0:2];
    logic [2:0]       lvl_dec;
    logic [2:0]       lvl_inc;

    logic [THREAD_ID_BITS-1:0] mem_q [0:2][0:QUEUE_DEPTH-1];
    logic [THREAD_ID_BITS-1:0] rdata_reg;
    logic [1:0]                pick_lvl_reg;
    logic [tlfs_pkg::QUANTUM_W-1:0] pick_q_reg;

    logic [1:0]                     status_reg;
    logic [THREAD_ID_BITS-1:0]      picked_reg;
    logic [1:0]                     level_reg;
    logic [tlfs_pkg::QUANTUM_W-1:0] quantum_reg;

    logic [SUM_W-1:0] total;
    logic [1:0]       pick_lvl;
    logic [1:0]       src_lvl;
    logic [1:0]       rd_lvl;
    logic [1:0]       wr_lvl;
    logic             rd_en;
    logic             wr_en;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] wr_head;
    logic [CNT_W-1:0] wr_count;
    logic [CNT_W:0]   tail_sum;
    logic [CNT_W:0]   tail_wrap;
    logic [PTR_W-1:0] wr_addr;
    logic [THREAD_ID_BITS-1:0] wr_data;

    assign total = SUM_W'(count_reg[0]) + SUM_W'(count_reg[1]) + SUM_W'(count_reg[2]);

    always_comb begin
        priority if (count_reg[tlfs_pkg::LVL_HIGH] != '0) begin
            pick_lvl = tlfs_pkg::LVL_HIGH;
        end else if (count_reg[tlfs_pkg::LVL_MEDIUM] != '0) begin
            pick_lvl = tlfs_pkg::LVL_MEDIUM;
        end else begin
            pick_lvl = tlfs_pkg::LVL_LOW;
        end
    end

    // Boost drains medium first, then low
    assign src_lvl = (count_reg[tlfs_pkg::LVL_MEDIUM] != '0) ? tlfs_pkg::LVL_MEDIUM
                                                              : tlfs_pkg::LVL_LOW;

    assign rd_en   = cmd.copy_rd | cmd.pop_rd;
    assign rd_lvl  = cmd.copy_rd ? src_lvl : pick_lvl;
    assign wr_en   = cmd.push | cmd.copy_wr;
    assign wr_lvl  = cmd.push ? tlfs_pkg::prio_to_level(prio_reg) : tlfs_pkg::LVL_HIGH;
    assign wr_data = cmd.push ? id_reg : rdata_reg;

    always_comb begin
        unique case (rd_lvl)
            tlfs_pkg::LVL_HIGH:   rd_addr = head_reg[2];
            tlfs_pkg::LVL_MEDIUM: rd_addr = head_reg[1];
            default:              rd_addr = head_reg[0];
        endcase
    end

    always_comb begin
        unique case (wr_lvl)
            tlfs_pkg::LVL_HIGH: begin
                wr_head  = head_reg[2];
                wr_count = count_reg[2];
            end
            tlfs_pkg::LVL_MEDIUM: begin
                wr_head  = head_reg[1];
                wr_count = count_reg[1];
            end
            default: begin
                wr_head  = head_reg[0];
                wr_count = count_reg[0];
            end
        endcase
    end

    // Tail is below twice the depth: one compare and subtract wraps it
    assign tail_sum  = (CNT_W + 1)'(wr_head) + (CNT_W + 1)'(wr_count);
    assign tail_wrap = (tail_sum >= DEPTH_EXT) ? (tail_sum - DEPTH_EXT) : tail_sum;
    assign wr_addr   = tail_wrap[PTR_W-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lvl_dec[i]    = rd_en && (rd_lvl == 2'(i));
            lvl_inc[i]    = wr_en && (wr_lvl == 2'(i));
            head_next[i]  = head_reg[i];
            if (lvl_dec[i]) begin
                head_next[i] = (head_reg[i] == LAST_PTR) ? '0 : head_reg[i] + 1'b1;
            end
            count_next[i] = count_reg[i] + CNT_W'(lvl_inc[i]) - CNT_W'(lvl_dec[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            last_tick_reg <= '0;
            q_high_reg    <= tlfs_pkg::QUANTUM_HIGH_RST;
            q_medium_reg  <= tlfs_pkg::QUANTUM_MEDIUM_RST;
            q_low_reg     <= tlfs_pkg::QUANTUM_LOW_RST;
        end else begin
            for (int i = 0; i < 3; i++) begin
                head_reg[i]  <= head_next[i];
                count_reg[i] <= count_next[i];
            end
            if (cmd.set_tick) begin
                last_tick_reg <= tick_reg;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    tlfs_pkg::CFG_QUANTUM_HIGH:   q_high_reg   <= cfg_wr_data;
                    tlfs_pkg::CFG_QUANTUM_MEDIUM: q_medium_reg <= cfg_wr_data;
                    tlfs_pkg::CFG_QUANTUM_LOW:    q_low_reg    <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_operation;
            id_reg   <= s_thread_id;
            prio_reg <= s_thread_priority;
            tick_reg <= s_tick_count;
        end
        if (wr_en) begin
            mem_q[wr_lvl][wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem_q[rd_lvl][rd_addr];
        end
        if (cmd.pop_rd) begin
            pick_lvl_reg <= pick_lvl;
            unique case (pick_lvl)
                tlfs_pkg::LVL_HIGH:   pick_q_reg <= q_high_reg;
                tlfs_pkg::LVL_MEDIUM: pick_q_reg <= q_medium_reg;
                default:              pick_q_reg <= q_low_reg;
            endcase
        end
        if (cmd.load_out) begin
            status_reg <= cmd.out_status;
            if (cmd.out_status == tlfs_pkg::ST_PICKED) begin
                picked_reg  <= rdata_reg;
                level_reg   <= pick_lvl_reg;
                quantum_reg <= pick_q_reg;
            end else begin
                picked_reg  <= '0;
                level_reg   <= tlfs_pkg::LVL_LOW;
                quantum_reg <= '0;
            end
        end
    end

    assign sts.dequeue      = (op_reg == tlfs_pkg::OP_DEQUEUE);
    assign sts.full         = (total >= DEPTH_SUM);
    assign sts.empty        = (total == '0);
    assign sts.tick_changed = (tick_reg != last_tick_reg);
    assign sts.src_nonempty = (count_reg[tlfs_pkg::LVL_MEDIUM] != '0) ||
                              (count_reg[tlfs_pkg::LVL_LOW] != '0);

    assign m_status        = status_reg;
    assign m_picked_thread = picked_reg;
    assign m_picked_level  = level_reg;
    assign m_quantum       = quantum_reg;

endmodule

@@ rtl/core/tlfs_ctrl.sv @@
// Controller of the scheduler: sequences enqueue, boost and pop, and owns
// the input ready and result valid flags. Depends on tlfs_pkg.
module tlfs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  tlfs_pkg::tlfs_sts_t sts,
    output tlfs_pkg::tlfs_cmd_t cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_BOOST    = 3'd2;
    localparam logic [2:0] S_POP      = 3'd3;
    localparam logic [2:0] S_POP_WAIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       copy_pend_reg;
    logic       copy_pend_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        cmd            = '0;
        cmd.out_status = tlfs_pkg::ST_ENQUEUED;
        state_next     = state_reg;
        copy_pend_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (!sts.dequeue) begin
                    if (out_free) begin
                        cmd.push       = !sts.full;
                        cmd.load_out   = 1'b1;
                        cmd.out_status = sts.full ? tlfs_pkg::ST_FULL
                                                  : tlfs_pkg::ST_ENQUEUED;
                        state_next     = S_IDLE;
                    end
                end else if (sts.empty) begin
                    if (out_free) begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = tlfs_pkg::ST_EMPTY;
                        state_next     = S_IDLE;
                    end
                end else if (sts.tick_changed) begin
                    cmd.set_tick = 1'b1;
                    state_next   = S_BOOST;
                end else begin
                    state_next = S_POP;
                end
            end
            S_BOOST: begin
                // read one entry per cycle, write the previous read behind it
                cmd.copy_rd    = sts.src_nonempty;
                cmd.copy_wr    = copy_pend_reg;
                copy_pend_next = sts.src_nonempty;
                if (!sts.src_nonempty) begin
                    state_next = S_POP;
                end
            end
            S_POP: begin
                cmd.pop_rd = 1'b1;
                state_next = S_POP_WAIT;
            end
            S_POP_WAIT: begin
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    cmd.out_status = tlfs_pkg::ST_PICKED;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid_next = cmd.load_out || (m_valid_reg && !m_ready);
    assign m_valid      = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            copy_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            copy_pend_reg <= copy_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

endmodule

@@ rtl/core/three_level_feedback_scheduler.sv @@
// Three-level feedback run-queue scheduler (top level; uses tlfs_pkg,
// tlfs_ctrl, tlfs_dpath and assert_macros.svh). Thread ids sit in three FIFO
// run queues, high, medium and low, that share QUEUE_DEPTH slots between
// them; operation 0 enqueues s_thread_id at the level given by
// s_thread_priority (2 high, 1 medium, anything else low) and answers status
// 0, or status 3 when all slots are taken. Operation 1 dequeues: with every
// queue empty it answers status 2 and leaves the stored tick alone;
// otherwise, if s_tick_count differs from the stored tick, the tick is
// recorded and all medium entries and then all low entries move in order to
// the tail of the high queue, after which the head of the highest non-empty
// queue is returned with status 1, its level and that level's quantum
// (picked fields read zero for every other status). One transaction is in
// work at a time. A boost moves at most QUEUE_DEPTH medium and low entries,
// one entry a cycle through the single read and single write port of the
// queue memory. The result sits in an output register, so the next
// transaction is accepted while a result waits; a result that finds the
// register still full holds the controller until m_ready frees it. Quantum
// registers are written through cfg_wr_en, cfg_index and cfg_wr_data (index
// 0 high, 1 medium, 2 low, 3 ignored); the user must write them only while
// the block is idle, which the block itself does not enforce. The queue
// memory needs no clearing pass after reset.
`include "assert_macros.svh"

module three_level_feedback_scheduler #(
    parameter int QUEUE_DEPTH    = 32,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input transactions
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [THREAD_ID_BITS-1:0]      s_thread_id,
    input  logic [1:0]                     s_thread_priority,
    input  logic [tlfs_pkg::TICK_W-1:0]    s_tick_count,
    // result transactions
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [THREAD_ID_BITS-1:0]      m_picked_thread,
    output logic [1:0]                     m_picked_level,
    output logic [tlfs_pkg::QUANTUM_W-1:0] m_quantum,
    // quantum register writes
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [tlfs_pkg::QUANTUM_W-1:0] cfg_wr_data
);

    tlfs_pkg::tlfs_cmd_t cmd;
    tlfs_pkg::tlfs_sts_t sts;

    // Sequence each transaction; hold s_ready low until its result is loaded
    tlfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Queue storage, pointers, quantum registers and the result register
    tlfs_dpath #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_operation       (s_operation),
        .s_thread_id       (s_thread_id),
        .s_thread_priority (s_thread_priority),
        .s_tick_count      (s_tick_count),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .cmd               (cmd),
        .sts               (sts),
        .m_status          (m_status),
        .m_picked_thread   (m_picked_thread),
        .m_picked_level    (m_picked_level),
        .m_quantum         (m_quantum)
    );

    // An accepted transaction blocks the input until its work is done
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // Never drop a result still waiting on the output
    `ASSERT_IMPLIES(a_no_result_overwrite, aclk, aresetn, cmd.load_out, !m_valid || m_ready)
    // The memory write port serves one writer per cycle
    `ASSERT_IMPLIES(a_single_writer, aclk, aresetn, cmd.push, !cmd.copy_wr)

endmodule
